[rtl/hst_pkg.sv]
// ============================================================================
// hst_pkg
// Shared types, widths and constants for the heading slew block.
// ============================================================================
`default_nettype none

package hst_pkg;

    // Coordinate and CORDIC sizing
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_ITERS = 14;
    localparam int GUARD_SHIFT  = 20;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int XY_W         = DIFF_W + GUARD_SHIFT + 3;
    localparam int Z_W          = 34;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int TBL_LEN      = 24;
    localparam int TBL_IDX_W    = 5;

    // Angle rounding from Q30 to Q3.13
    localparam int ROUND_SHIFT  = 17;
    localparam int ROUND_BIAS   = 65536;
    localparam int ZR_W         = Z_W - ROUND_SHIFT;
    localparam int Q30_HALF_PI  = 1686629713;

    // Q3.13 angles
    localparam int ANG_W        = 16;
    localparam int ERR_W        = ANG_W + 1;
    localparam int ANG_PI       = 25736;
    localparam int ANG_TWO_PI   = 51472;

    // Configuration registers
    localparam int CFG_W        = 15;
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_STEP   = 1'b1;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 15'd410;
    localparam logic [CFG_W-1:0] TURN_STEP_RESET = 15'd2458;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              rotate;
        logic [ITER_W-1:0] iter;
        logic              round;
        logic              wrap_err;
        logic              limit;
        logic              commit;
    } hst_cmd_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [TBL_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            5'd0:    val = Z_W'(843314857);
            5'd1:    val = Z_W'(497837829);
            5'd2:    val = Z_W'(263043837);
            5'd3:    val = Z_W'(133525159);
            5'd4:    val = Z_W'(67021687);
            5'd5:    val = Z_W'(33543516);
            5'd6:    val = Z_W'(16775851);
            5'd7:    val = Z_W'(8388437);
            5'd8:    val = Z_W'(4194283);
            5'd9:    val = Z_W'(2097149);
            5'd10:   val = Z_W'(1048575);
            5'd11:   val = Z_W'(524288);
            5'd12:   val = Z_W'(262144);
            5'd13:   val = Z_W'(131072);
            5'd14:   val = Z_W'(65536);
            5'd15:   val = Z_W'(32768);
            5'd16:   val = Z_W'(16384);
            5'd17:   val = Z_W'(8192);
            5'd18:   val = Z_W'(4096);
            5'd19:   val = Z_W'(2048);
            5'd20:   val = Z_W'(1024);
            5'd21:   val = Z_W'(512);
            5'd22:   val = Z_W'(256);
            5'd23:   val = Z_W'(128);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/hst_ctrl.sv]
// ============================================================================
// hst_ctrl
// Sequencer for one heading update: load, CORDIC rotations, round, error
// wrap, turn limit and result commit into the output register.
// ============================================================================
`default_nettype none

module hst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hst_pkg::hst_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND,
        ST_ERR,
        ST_LIMIT,
        ST_DONE
    } state_t;

    localparam logic [hst_pkg::ITER_W-1:0] ITER_LAST =
        hst_pkg::ITER_W'(hst_pkg::CORDIC_ITERS - 1);

    state_t                      state_reg;
    state_t                      state_next;
    logic [hst_pkg::ITER_W-1:0]  iter_reg;
    logic [hst_pkg::ITER_W-1:0]  iter_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        commit;

    // The result can be written when the output register is empty or drains now.
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Command decode
    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_valid && (state_reg == ST_IDLE);
        cmd.rotate   = (state_reg == ST_ITER);
        cmd.iter     = iter_reg;
        cmd.round    = (state_reg == ST_ROUND);
        cmd.wrap_err = (state_reg == ST_ERR);
        cmd.limit    = (state_reg == ST_LIMIT);
        cmd.commit   = commit;
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ITER;
                    iter_next  = '0;
                end
            end
            ST_ITER:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_ROUND: state_next = ST_ERR;
            ST_ERR:   state_next = ST_LIMIT;
            ST_LIMIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/hst_dp.sv]
// ============================================================================
// hst_dp
// Datapath: CORDIC vectoring for the bearing, heading error wrap, turn
// limiting, heading state, configuration and the output register.
// ============================================================================
`default_nettype none

module hst_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire hst_pkg::hst_cmd_t                      cmd,
    input  wire logic                                   cfg_we,
    input  wire logic [hst_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [hst_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  agent_col,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  agent_row,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  goal_col,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  goal_row,
    output logic signed [hst_pkg::ANG_W-1:0]            new_heading,
    output logic signed [hst_pkg::ANG_W-1:0]            heading_error,
    output logic                                        facing
);

    localparam int XY_W  = hst_pkg::XY_W;
    localparam int Z_W   = hst_pkg::Z_W;
    localparam int DW    = hst_pkg::DIFF_W;
    localparam int AW    = hst_pkg::ANG_W;
    localparam int EW    = hst_pkg::ERR_W;
    localparam int ZRW   = hst_pkg::ZR_W;

    localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(hst_pkg::Q30_HALF_PI);
    localparam logic signed [Z_W-1:0] BIAS_Z    = Z_W'(hst_pkg::ROUND_BIAS);
    localparam logic signed [ZRW-1:0] PI_ZR     = ZRW'(hst_pkg::ANG_PI);
    localparam logic signed [EW-1:0]  PI_E      = EW'(hst_pkg::ANG_PI);
    localparam logic signed [EW-1:0]  TWO_PI_E  = EW'(hst_pkg::ANG_TWO_PI);

    // Configuration and heading state
    logic [hst_pkg::CFG_W-1:0] thr_reg;
    logic [hst_pkg::CFG_W-1:0] max_step_reg;
    logic signed [AW-1:0]      heading_reg;

    // Working registers
    logic signed [XY_W-1:0]    x_reg;
    logic signed [XY_W-1:0]    y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      zero_reg;
    logic signed [AW-1:0]      desired_reg;
    logic signed [AW-1:0]      diff_reg;
    logic signed [AW-1:0]      step_reg;
    logic                      face_reg;

    // Output register
    logic signed [AW-1:0]      new_heading_reg;
    logic signed [AW-1:0]      heading_error_reg;
    logic                      facing_reg;

    // Load stage signals
    logic signed [DW-1:0]      dx;
    logic signed [DW-1:0]      dy;
    logic signed [DW-1:0]      px;
    logic signed [DW-1:0]      py;
    logic signed [Z_W-1:0]     pz;
    logic signed [XY_W-1:0]    x_init;
    logic signed [XY_W-1:0]    y_init;

    // Rotation signals
    logic signed [XY_W-1:0]    xs;
    logic signed [XY_W-1:0]    ys;
    logic signed [Z_W-1:0]     atan_val;
    logic signed [XY_W-1:0]    x_next;
    logic signed [XY_W-1:0]    y_next;
    logic signed [Z_W-1:0]     z_next;

    // Round, wrap, limit and commit signals
    logic signed [Z_W-1:0]     z_biased;
    logic signed [ZRW-1:0]     z_round;
    logic signed [AW-1:0]      desired_next;
    logic signed [EW-1:0]      raw_diff;
    logic signed [EW-1:0]      diff_wrap;
    logic signed [AW-1:0]      mag;
    logic signed [EW-1:0]      diff_ext;
    logic signed [EW-1:0]      max_pos;
    logic signed [EW-1:0]      max_neg;
    logic signed [EW-1:0]      step_lim;
    logic signed [EW-1:0]      turn_sum;
    logic signed [EW-1:0]      turn_wrap;
    logic signed [AW-1:0]      heading_next;

    // Coordinate differences and pre-rotation into the right half plane
    always_comb
    begin
        dx = DW'(goal_col) - DW'(agent_col);
        dy = DW'(goal_row) - DW'(agent_row);
        if (dx[DW-1])
        begin
            if (!dy[DW-1])
            begin
                px = dy;
                py = -dx;
                pz = HALF_PI_Z;
            end
            else
            begin
                px = -dy;
                py = dx;
                pz = -HALF_PI_Z;
            end
        end
        else
        begin
            px = dx;
            py = dy;
            pz = '0;
        end
        x_init = XY_W'(px) <<< hst_pkg::GUARD_SHIFT;
        y_init = XY_W'(py) <<< hst_pkg::GUARD_SHIFT;
    end

    // One CORDIC micro-rotation per cycle, driving y toward zero
    always_comb
    begin
        xs       = x_reg >>> cmd.iter;
        ys       = y_reg >>> cmd.iter;
        atan_val = hst_pkg::atan_q30(hst_pkg::TBL_IDX_W'(cmd.iter));
        if (!y_reg[XY_W-1])
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
    end

    // Round the Q30 angle to Q3.13 and clamp to plus or minus pi; a zero difference gives zero
    always_comb
    begin
        z_biased = z_reg + BIAS_Z;
        z_round  = $signed(z_biased[Z_W-1:hst_pkg::ROUND_SHIFT]);
        if (zero_reg)
        begin
            desired_next = '0;
        end
        else if (z_round > PI_ZR)
        begin
            desired_next = AW'(PI_ZR);
        end
        else if (z_round < -PI_ZR)
        begin
            desired_next = AW'(-PI_ZR);
        end
        else
        begin
            desired_next = AW'(z_round);
        end
    end

    // Heading error, wrapped once into the range of plus or minus pi
    always_comb
    begin
        raw_diff = EW'(desired_reg) - EW'(heading_reg);
        priority if (raw_diff > PI_E)
        begin
            diff_wrap = raw_diff - TWO_PI_E;
        end
        else if (raw_diff < -PI_E)
        begin
            diff_wrap = raw_diff + TWO_PI_E;
        end
        else
        begin
            diff_wrap = raw_diff;
        end
    end

    // Facing test and turn limit
    always_comb
    begin
        mag      = diff_reg[AW-1] ? -diff_reg : diff_reg;
        diff_ext = EW'(diff_reg);
        max_pos  = $signed({{(EW - hst_pkg::CFG_W){1'b0}}, max_step_reg});
        max_neg  = -max_pos;
        priority if (diff_ext > max_pos)
        begin
            step_lim = max_pos;
        end
        else if (diff_ext < max_neg)
        begin
            step_lim = max_neg;
        end
        else
        begin
            step_lim = diff_ext;
        end
    end

    // New heading: snap when facing, otherwise turn and wrap
    always_comb
    begin
        turn_sum = EW'(heading_reg) + EW'(step_reg);
        priority if (turn_sum > PI_E)
        begin
            turn_wrap = turn_sum - TWO_PI_E;
        end
        else if (turn_sum < -PI_E)
        begin
            turn_wrap = turn_sum + TWO_PI_E;
        end
        else
        begin
            turn_wrap = turn_sum;
        end
        heading_next = face_reg ? desired_reg : AW'(turn_wrap);
    end

    // Configuration registers and heading state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= hst_pkg::THRESHOLD_RESET;
            max_step_reg <= hst_pkg::TURN_STEP_RESET;
            heading_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hst_pkg::REG_ANGLE_THRESHOLD: thr_reg      <= cfg_data;
                    hst_pkg::REG_MAX_TURN_STEP:   max_step_reg <= cfg_data;
                    default:                      thr_reg      <= thr_reg;
                endcase
            end
            if (cmd.commit)
            begin
                heading_reg <= heading_next;
            end
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= pz;
            zero_reg <= (dx == '0) && (dy == '0);
        end
        if (cmd.rotate)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.round)
        begin
            desired_reg <= desired_next;
        end
        if (cmd.wrap_err)
        begin
            diff_reg <= AW'(diff_wrap);
        end
        if (cmd.limit)
        begin
            step_reg <= AW'(step_lim);
            face_reg <= (mag[hst_pkg::CFG_W-1:0] < thr_reg);
        end
        if (cmd.commit)
        begin
            new_heading_reg   <= heading_next;
            heading_error_reg <= diff_reg;
            facing_reg        <= face_reg;
        end
    end

    assign new_heading   = new_heading_reg;
    assign heading_error = heading_error_reg;
    assign facing        = facing_reg;

endmodule

`default_nettype wire

[rtl/heading_slew_toward_target.sv]
// ============================================================================
// heading_slew_toward_target
// Rate-limited heading tracking toward a grid target.
// ============================================================================
// Usage:
// - Input channel (in_valid/in_ready) carries agent and goal grid coordinates.
//   A transfer happens when both are high; in_ready is high only while the
//   block is idle, so one item is in flight at a time.
// - Output channel (out_valid/out_ready) carries new_heading, heading_error
//   and facing from an output register. The next input is accepted while a
//   result still waits to be taken.
// - Sequence: the input transfer loads the operands, followed by 14 CORDIC
//   micro-rotations on a single shared shift-add unit, then round, error
//   wrap, turn limit and commit. The block is idle again the cycle after
//   commit, so it takes no new item until the previous one is committed.
// - If the receiver stalls, a finished item waits in the commit step until
//   the output register drains; the heading state updates only at commit.
// - Configuration: cfg_we with cfg_index 0 (angle threshold) or 1 (max turn
//   step) writes cfg_data; write only while idle.
// - Reset clears the heading to zero and loads the default threshold and turn
//   step; no output is valid after reset.
// ============================================================================
`default_nettype none

module heading_slew_toward_target (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [hst_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [hst_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  agent_col,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  agent_row,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  goal_col,
    input  wire logic signed [hst_pkg::COORD_BITS-1:0]  goal_row,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [hst_pkg::ANG_W-1:0]            new_heading,
    output logic signed [hst_pkg::ANG_W-1:0]            heading_error,
    output logic                                        facing
);

    hst_pkg::hst_cmd_t cmd;

    // Sequencer
    hst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Arithmetic and state
    hst_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .agent_col     (agent_col),
        .agent_row     (agent_row),
        .goal_col      (goal_col),
        .goal_row      (goal_row),
        .new_heading   (new_heading),
        .heading_error (heading_error),
        .facing        (facing)
    );

endmodule

`default_nettype wire

[rtl/hst_checker.sv]
// ============================================================================
// hst_checker
// Port-level checks for the heading slew block, bound to the top level.
// ============================================================================
`default_nettype none

module hst_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic signed [hst_pkg::ANG_W-1:0]  new_heading,
    input  wire logic signed [hst_pkg::ANG_W-1:0]  heading_error,
    input  wire logic                              facing
);

    localparam logic signed [hst_pkg::ANG_W-1:0] PI_A = hst_pkg::ANG_W'(hst_pkg::ANG_PI);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_heading)
            && $stable(heading_error) && $stable(facing))
    else $error("result changed while stalled");

    // After an input transfer the block is busy with that item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

    // A result cannot appear in the cycle right after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

    // Presented angles stay within plus or minus pi.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> new_heading <= PI_A && new_heading >= -PI_A
            && heading_error <= PI_A && heading_error >= -PI_A)
    else $error("angle out of range");

endmodule

bind heading_slew_toward_target hst_checker u_hst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_heading   (new_heading),
    .heading_error (heading_error),
    .facing        (facing)
);

`default_nettype wire

[tb/heading_slew_toward_target_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// heading_slew_toward_target_tb
// Self-checking regression for the rate-limited heading tracker. A local
// CORDIC bearing predictor keeps its own heading and register copies, works
// out each result when the input transfer happens, and a checker compares
// every output transfer with the oldest prediction. Directed geometry and
// register extremes come first, then a long output hold-off, then random
// tracking episodes under changing settings and random idling on both sides.
// ============================================================================

module heading_slew_toward_target_tb;

    import hst_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 24;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned RANDOM_ITEMS    = 1000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        logic signed [ANG_W-1:0] new_heading;
        logic signed [ANG_W-1:0] heading_error;
        logic                    facing;
    } heading_result_t;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n;

    // Block ports
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    coord_t               agent_col;
    coord_t               agent_row;
    coord_t               goal_col;
    coord_t               goal_row;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [ANG_W-1:0] new_heading;
    logic signed [ANG_W-1:0] heading_error;
    logic                 facing;

    // Predictor state and register copies
    int               model_heading;
    logic [CFG_W-1:0] model_threshold;
    logic [CFG_W-1:0] model_turn_limit;
    heading_result_t  pending_headings[$];

    // Run control and bookkeeping
    bit          sender_idles;
    bit          receiver_idles;
    bit          hold_off_request;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned facing_seen;
    int unsigned register_writes;

    heading_slew_toward_target dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .agent_col     (agent_col),
        .agent_row     (agent_row),
        .goal_col      (goal_col),
        .goal_row      (goal_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_heading   (new_heading),
        .heading_error (heading_error),
        .facing        (facing)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Arctangent of 2^-i in Q30 radians.
    function automatic longint atan_of_pow2(int i);
        case (i)
            0:       return 843314857;
            1:       return 497837829;
            2:       return 263043837;
            3:       return 133525159;
            4:       return 67021687;
            5:       return 33543516;
            6:       return 16775851;
            7:       return 8388437;
            8:       return 4194283;
            9:       return 2097149;
            10:      return 1048575;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    // Bearing of (dx, dy) in Q3.13 radians from a vectoring CORDIC.
    function automatic int cordic_bearing(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint t;
        if (dx == 0 && dy == 0)
            return 0;
        z = 0;
        // Pre-rotate the left half plane by a quarter turn.
        if (dx < 0)
        begin
            if (dy >= 0)
            begin
                x = dy;
                y = -dx;
                z = longint'(Q30_HALF_PI);
            end
            else
            begin
                x = -dy;
                y = dx;
                z = -longint'(Q30_HALF_PI);
            end
        end
        else
        begin
            x = dx;
            y = dy;
        end
        x = x <<< GUARD_SHIFT;
        y = y <<< GUARD_SHIFT;
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++)
        begin
            t = x;
            if (y >= 0)
            begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + atan_of_pow2(i);
            end
            else
            begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - atan_of_pow2(i);
            end
        end
        // Round from Q30 to Q3.13 and keep within [-pi, pi].
        z = (z + 65536) >>> 17;
        if (z > ANG_PI)
            z = ANG_PI;
        if (z < -ANG_PI)
            z = -ANG_PI;
        return int'(z);
    endfunction

    // Advance the predicted heading by one tick and queue the expected result.
    task automatic slew_heading(coord_t ac, coord_t ar, coord_t gc, coord_t gr);
        heading_result_t want;
        int desired;
        int diff;
        int mag;
        int turn;
        int next_heading;
        desired = cordic_bearing(longint'(gc) - longint'(ac), longint'(gr) - longint'(ar));
        diff = desired - model_heading;
        if (diff > ANG_PI)
            diff -= ANG_TWO_PI;
        if (diff < -ANG_PI)
            diff += ANG_TWO_PI;
        mag = (diff < 0) ? -diff : diff;
        if (mag < int'(model_threshold))
        begin
            next_heading = desired;
            want.facing = 1'b1;
        end
        else
        begin
            turn = diff;
            if (turn > int'(model_turn_limit))
                turn = int'(model_turn_limit);
            if (turn < -int'(model_turn_limit))
                turn = -int'(model_turn_limit);
            next_heading = model_heading + turn;
            if (next_heading > ANG_PI)
                next_heading -= ANG_TWO_PI;
            if (next_heading < -ANG_PI)
                next_heading += ANG_TWO_PI;
            want.facing = 1'b0;
        end
        model_heading = next_heading;
        want.new_heading = ANG_W'(next_heading);
        want.heading_error = ANG_W'(diff);
        pending_headings.push_back(want);
    endtask

    function automatic int unsigned draw_gap(bit enabled);
        return enabled ? $urandom_range(0, 13) : 0;
    endfunction

    function automatic coord_t to_coord(int v);
        if (v > 32767)
            return coord_t'(32767);
        if (v < -32768)
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_angle_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_W'(ANG_PI);
            2:       return '1;
            3:       return CFG_W'($urandom_range(1, 1200));
            4:       return CFG_W'($urandom_range(0, 32767));
            default: return CFG_W'($urandom_range(200, 5000));
        endcase
    endfunction

    // Offer one coordinate set and predict its result on the input transfer.
    task automatic send_item(coord_t ac, coord_t ar, coord_t gc, coord_t gr);
        int unsigned gap;
        gap = draw_gap(sender_idles);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        agent_col <= ac;
        agent_row <= ar;
        goal_col  <= gc;
        goal_row  <= gr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        slew_heading(ac, ar, gc, gr);
        items_sent++;
    endtask

    // Let every outstanding result drain, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_ANGLE_THRESHOLD: model_threshold  = value;
            REG_MAX_TURN_STEP:   model_turn_limit = value;
            default: ;
        endcase
        register_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] threshold, logic [CFG_W-1:0] turn_limit);
        wait_idle();
        write_register(REG_ANGLE_THRESHOLD, threshold);
        write_register(REG_MAX_TURN_STEP, turn_limit);
    endtask

    task automatic send_random_directions(int unsigned count);
        repeat (count) send_item(any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    // Axis directions, zero difference, coordinate extremes, both left-half
    // pre-rotations, an error of exactly pi and the wrap across the -pi seam.
    task automatic test_directed_geometry();
        send_item(0, 0, 0, 0);
        send_item(5, -7, 5, -7);
        send_item(0, 0, 100, 0);
        send_item(0, 0, 0, 100);
        send_item(0, 0, 0, -100);
        send_item(-32768, -32768, 32767, 32767);
        send_item(32767, 32767, -32768, -32768);
        send_item(32767, -32768, -32768, 32767);
        send_item(-32768, 32767, 32767, -32768);
        send_item(0, 0, -1, 1);
        send_item(0, 0, -1, -1);
        send_item(0, 0, 100, 0);
        // Due west from a zero heading: error of pi, then slew until snapped.
        repeat (12) send_item(0, 0, -100, 0);
        // Just south of west: the error wraps across the seam.
        repeat (2) send_item(0, 0, -30000, -1);
    endtask

    // Threshold and turn step at zero, at pi and at full scale.
    task automatic test_register_extremes();
        apply_settings('0, TURN_STEP_RESET);
        send_item(3, 3, 3, 3);
        send_random_directions(3);
        apply_settings('1, '0);
        send_random_directions(4);
        apply_settings(CFG_W'(ANG_PI), CFG_W'(ANG_PI));
        send_item(0, 0, 100, 0);
        send_item(0, 0, -100, 0);
        send_random_directions(3);
        apply_settings('0, '0);
        send_random_directions(3);
        apply_settings('0, CFG_W'(ANG_PI));
        send_random_directions(4);
        apply_settings('0, '1);
        send_random_directions(4);
        apply_settings(THRESHOLD_RESET, TURN_STEP_RESET);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_hold_off();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_off_request = 1'b1;
        send_random_directions(12);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        wait_idle();
    endtask

    // Tracking episodes toward a mostly fixed goal, mixed with noise.
    task automatic test_random_tracking(int unsigned target);
        int unsigned first_item;
        int unsigned episode;
        int unsigned ticks;
        int ac;
        int ar;
        int gc;
        int gr;
        int spread;
        coord_t pc;
        coord_t pr;
        first_item = items_sent;
        episode = 0;
        while (items_sent - first_item < target)
        begin
            if (episode % 10 == 9)
                apply_settings(pick_angle_setting(), pick_angle_setting());
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1:
                    send_random_directions($urandom_range(1, 4));
                2:
                begin
                    pc = any_coord();
                    pr = any_coord();
                    repeat ($urandom_range(1, 3)) send_item(pc, pr, pc, pr);
                end
                default:
                begin
                    gc = int'(any_coord());
                    gr = int'(any_coord());
                    case ($urandom_range(0, 2))
                        0:       spread = 8;
                        1:       spread = 400;
                        default: spread = 40000;
                    endcase
                    ac = gc + int'($urandom_range(0, 2 * spread)) - spread;
                    ar = gr + int'($urandom_range(0, 2 * spread)) - spread;
                    ticks = $urandom_range(3, 14);
                    repeat (ticks)
                    begin
                        send_item(to_coord(ac), to_coord(ar), to_coord(gc), to_coord(gr));
                        ac += int'($urandom_range(0, 2)) - 1;
                        ar += int'($urandom_range(0, 2)) - 1;
                        if ($urandom_range(0, 7) == 0)
                            gc += int'($urandom_range(0, 20)) - 10;
                    end
                end
            endcase
            episode++;
        end
    endtask

    // Receiver: per-result random stall, plus a long hold-off on request.
    initial
    begin : receiver
        int unsigned gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                gap = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            else
                gap = draw_gap(receiver_idles);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready) && !hold_off_request)
                @(posedge clk);
        end
    end

    // Compare every output transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_result
        heading_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_headings.size() == 0)
            begin
                $error("result transfer with no prediction waiting");
                error_count++;
            end
            else
            begin
                want = pending_headings.pop_front();
                results_seen++;
                if (facing === 1'b1)
                    facing_seen++;
                if (new_heading !== want.new_heading)
                begin
                    $error("new_heading: expected %0d, got %0d", want.new_heading, new_heading);
                    error_count++;
                end
                if (heading_error !== want.heading_error)
                begin
                    $error("heading_error: expected %0d, got %0d",
                           want.heading_error, heading_error);
                    error_count++;
                end
                if (facing !== want.facing)
                begin
                    $error("facing: expected %0d, got %0d", want.facing, facing);
                    error_count++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("cycle limit reached with %0d results outstanding",
                   pending_headings.size());
            $display("heading_slew_toward_target regression: fail");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        agent_col       <= '0;
        agent_row       <= '0;
        goal_col        <= '0;
        goal_row        <= '0;
        model_heading    = 0;
        model_threshold  = THRESHOLD_RESET;
        model_turn_limit = TURN_STEP_RESET;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        hold_off_request = 1'b0;
        cycle_count      = 0;
        error_count      = 0;
        items_sent       = 0;
        results_seen     = 0;
        facing_seen      = 0;
        register_writes  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_geometry();
        test_register_extremes();
        test_output_hold_off();
        test_random_tracking(RANDOM_ITEMS);
        wait_idle();

        $display("Covered %0d coordinate sets and %0d results, %0d of them facing.",
                 items_sent, results_seen, facing_seen);
        $display("Made %0d register writes over %0d cycles, including a %0d-cycle hold-off.",
                 register_writes, cycle_count, HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("heading_slew_toward_target regression: pass");
        else
            $display("heading_slew_toward_target regression: fail");
        $finish;
    end

endmodule
